// ----- rtl/adcab_pkg.sv -----
// ----------------------------------------------------------------------------
// adcab_pkg
// Shared types and constants for the adc average band pwm block.
// ----------------------------------------------------------------------------
package adcab_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 14;
    localparam int PERIOD_W  = 10;
    localparam int COUNT_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    // four samples per average, so the count ends at three
    localparam logic [COUNT_W-1:0] LAST_SAMPLE = 2'd3;

    localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = 12'd1241;
    localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 12'd2482;
    localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST     = 10'd50;

    // duty offset in percent
    localparam logic [7:0] DUTY_BASE = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THRESHOLD  = 2'd0,
        CFG_HIGH_THRESHOLD = 2'd1,
        CFG_PWM_PERIOD     = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        BAND_LOW  = 2'd0,
        BAND_MID  = 2'd1,
        BAND_HIGH = 2'd2
    } t_band;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
    } t_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] low_threshold;
        logic [SAMPLE_W-1:0] high_threshold;
        logic [PERIOD_W-1:0] pwm_period;
    } t_cfg;

    typedef struct packed {
        logic  pwm_out;
        logic  indicator_out;
        logic  pwm_active;
        logic  band_valid;
        t_band band;
    } t_result;

endpackage

// ----- rtl/adcab_cfg.sv -----
// ----------------------------------------------------------------------------
// adcab_cfg
// Configuration register file: thresholds and pwm period.
// ----------------------------------------------------------------------------
module adcab_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [adcab_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [adcab_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output adcab_pkg::t_cfg                 o_cfg
);
    import adcab_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LOW_THRESHOLD:  n_cfg.low_threshold  = i_cfg_data;
                CFG_HIGH_THRESHOLD: n_cfg.high_threshold = i_cfg_data;
                CFG_PWM_PERIOD:     n_cfg.pwm_period     = i_cfg_data[PERIOD_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold  <= LOW_THRESHOLD_RST;
            r_cfg.high_threshold <= HIGH_THRESHOLD_RST;
            r_cfg.pwm_period     <= PWM_PERIOD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/adcab_in_reg.sv -----
// ----------------------------------------------------------------------------
// adcab_in_reg
// Input register stage, holds one transaction until the core takes it.
// ----------------------------------------------------------------------------
module adcab_in_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_op,
    input  logic [adcab_pkg::SAMPLE_W-1:0] i_sample,
    output logic                           o_item_valid,
    output adcab_pkg::t_item               o_item,
    input  logic                           i_item_take
);
    import adcab_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    // register may refill in the same cycle it is drained
    assign o_stall      = r_valid && !i_item_take;
    assign w_load       = i_valid && !o_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_item_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.op     <= i_op;
            r_item.sample <= i_sample;
        end
    end

endmodule

// ----- rtl/adcab_core.sv -----
// ----------------------------------------------------------------------------
// adcab_core
// Averaging, band decision, pwm counter and result register.
// ----------------------------------------------------------------------------
module adcab_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adcab_pkg::t_cfg     i_cfg,
    input  logic                i_item_valid,
    input  adcab_pkg::t_item    i_item,
    output logic                o_item_take,
    output logic                o_valid,
    input  logic                i_stall,
    output adcab_pkg::t_result  o_result
);
    import adcab_pkg::*;

    logic [COUNT_W-1:0]  r_count;
    logic [SUM_W-1:0]    r_sum;
    logic                r_running;
    logic [PERIOD_W-1:0] r_tick;
    logic [PERIOD_W-1:0] r_compare;
    logic                r_level;
    logic                r_indicator;
    logic                r_out_valid;
    t_result             r_result;

    logic [COUNT_W-1:0]  n_count;
    logic [SUM_W-1:0]    n_sum;
    logic                n_running;
    logic [PERIOD_W-1:0] n_tick;
    logic [PERIOD_W-1:0] n_compare;
    logic                n_level;
    logic                n_indicator;
    t_result             n_result;

    logic [SUM_W-1:0]    w_sum;
    logic [SUM_W-1:0]    w_lo;
    logic [SUM_W-1:0]    w_hi;
    logic [SUM_W+5:0]    w_prod;
    logic [7:0]          w_duty;
    logic [PERIOD_W:0]   w_next;
    logic                w_take;

    assign w_take      = i_item_valid && (!r_out_valid || !i_stall);
    assign o_item_take = w_take;
    assign o_valid     = r_out_valid;
    assign o_result    = r_result;

    assign w_sum  = r_sum + SUM_W'(i_item.sample);
    assign w_lo   = {i_cfg.low_threshold, 2'b00};
    assign w_hi   = {i_cfg.high_threshold, 2'b00};
    // sum * 33 as shift and add
    assign w_prod = {1'b0, w_sum, 5'b00000} + (SUM_W+6)'(w_sum);
    assign w_duty = DUTY_BASE + 8'(w_prod[SUM_W+5:12]);
    assign w_next = {1'b0, r_tick} + 11'd1;

    always_comb begin
        n_count     = r_count;
        n_sum       = r_sum;
        n_running   = r_running;
        n_tick      = r_tick;
        n_compare   = r_compare;
        n_level     = r_level;
        n_indicator = r_indicator;
        n_result.band_valid = 1'b0;
        n_result.band       = BAND_LOW;

        if (!i_item.op) begin
            if (r_running) begin
                if (w_next >= {1'b0, i_cfg.pwm_period}) begin
                    n_tick  = '0;
                    n_level = 1'b1;
                end else begin
                    n_tick = w_next[PERIOD_W-1:0];
                end
                // low at compare wins over high at wrap
                if (n_tick == r_compare) begin
                    n_level = 1'b0;
                end
            end
        end else if (r_count == LAST_SAMPLE) begin
            n_count = '0;
            n_sum   = '0;
            n_result.band_valid = 1'b1;
            if (w_sum <= w_lo) begin
                n_running     = 1'b0;
                n_indicator   = 1'b0;
                n_result.band = BAND_LOW;
            end else if (w_sum <= w_hi) begin
                n_compare     = PERIOD_W'(w_duty[7:1]);
                n_tick        = '0;
                n_running     = 1'b1;
                n_result.band = BAND_MID;
            end else begin
                n_running     = 1'b0;
                n_indicator   = 1'b1;
                n_result.band = BAND_HIGH;
            end
        end else begin
            n_count = r_count + 2'd1;
            n_sum   = w_sum;
        end

        n_result.pwm_out       = n_level;
        n_result.indicator_out = n_indicator;
        n_result.pwm_active    = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_running   <= 1'b0;
            r_tick      <= '0;
            r_compare   <= '0;
            r_level     <= 1'b0;
            r_indicator <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_count     <= n_count;
                r_sum       <= n_sum;
                r_running   <= n_running;
                r_tick      <= n_tick;
                r_compare   <= n_compare;
                r_level     <= n_level;
                r_indicator <= n_indicator;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result <= n_result;
        end
    end

`ifndef ASSERT_OFF
    a_count_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_item.op && r_count == LAST_SAMPLE) |=> (r_count == '0 && r_sum == '0))
        else $error("sample count not cleared after average");

    a_band_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_result.band_valid) |-> (r_result.band == BAND_LOW))
        else $error("band not zero without average");

    a_mid_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.band_valid) |->
        (r_result.pwm_active == (r_result.band == BAND_MID)))
        else $error("pwm running state disagrees with band");

    a_high_sets_ind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.band_valid && r_result.band == BAND_HIGH)
        |-> r_result.indicator_out)
        else $error("indicator not set on high band");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_result)))
        else $error("result lost while downstream stalled");
`endif

endmodule

// ----- rtl/adc_average_band_pwm.sv -----
// ----------------------------------------------------------------------------
// adc_average_band_pwm
// ADC four-sample average, band classification and pwm generator.
// ----------------------------------------------------------------------------
// path: input register, then core state update, then result register
// throughput: one transaction per cycle while the receiver does not stall,
// set by the state update in the core between the input and result registers
// reset: synchronous, active low; state cleared, registers to default values
module adc_average_band_pwm (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_op,
    input  logic [adcab_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_pwm_out,
    output logic                            o_indicator_out,
    output logic                            o_pwm_active,
    output logic                            o_band_valid,
    output logic [1:0]                      o_band,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [adcab_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [adcab_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import adcab_pkg::*;

    t_cfg    w_cfg;
    logic    w_item_valid;
    t_item   w_item;
    logic    w_item_take;
    t_result w_result;

    adcab_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    adcab_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_sample     (i_sample),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_take  (w_item_take)
    );

    adcab_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_take  (w_item_take),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result     (w_result)
    );

    assign o_pwm_out       = w_result.pwm_out;
    assign o_indicator_out = w_result.indicator_out;
    assign o_pwm_active    = w_result.pwm_active;
    assign o_band_valid    = w_result.band_valid;
    assign o_band          = w_result.band;

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for adc_average_band_pwm. Ticks and adc samples go in
// with random sender gaps. The receiver stalls at random. A scoreboard class
// predicts the pin levels, the running flag and the band of every
// transaction, and checks each result field by field. Register settings
// change between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import adcab_pkg::*;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_SAMPLE   = 1'b1;
    localparam int   LATENCY     = 2;
    localparam int   QUIET_LIMIT = 4000;

    class band_pwm_scoreboard;
        logic [SAMPLE_W-1:0] low_thr;
        logic [SAMPLE_W-1:0] high_thr;
        logic [PERIOD_W-1:0] period;
        logic [COUNT_W-1:0]  count;
        logic [SUM_W-1:0]    sum;
        logic                running;
        logic [PERIOD_W-1:0] tick;
        logic [PERIOD_W-1:0] cmp;
        logic                level;
        logic                ind;
        t_result             expected_levels[$];
        int                  errors;
        int                  items;
        int                  band_hits[3];

        function new();
            low_thr  = LOW_THRESHOLD_RST;
            high_thr = HIGH_THRESHOLD_RST;
            period   = PWM_PERIOD_RST;
            count    = '0;
            sum      = '0;
            running  = 1'b0;
            tick     = '0;
            cmp      = '0;
            level    = 1'b0;
            ind      = 1'b0;
            errors   = 0;
            items    = 0;
            band_hits = '{0, 0, 0};
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (t_cfg_index'(idx))
                CFG_LOW_THRESHOLD:  low_thr  = data[SAMPLE_W-1:0];
                CFG_HIGH_THRESHOLD: high_thr = data[SAMPLE_W-1:0];
                CFG_PWM_PERIOD:     period   = data[PERIOD_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(logic op, logic [SAMPLE_W-1:0] sample);
            logic [PERIOD_W:0] nxt;
            int unsigned       duty;
            t_result           res;
            res.band_valid = 1'b0;
            res.band       = BAND_LOW;
            if (op == OP_TICK) begin
                if (running) begin
                    nxt = {1'b0, tick} + 1'b1;
                    if (nxt >= {1'b0, period}) begin
                        tick  = '0;
                        level = 1'b1;
                    end else begin
                        tick = nxt[PERIOD_W-1:0];
                    end
                    // a low on the compare wins over the high of a wrap
                    if (tick == cmp)
                        level = 1'b0;
                end
            end else begin
                sum = sum + SUM_W'(sample);
                if (count == LAST_SAMPLE) begin
                    res.band_valid = 1'b1;
                    if (int'(sum) <= 4 * int'(low_thr)) begin
                        running  = 1'b0;
                        ind      = 1'b0;
                        res.band = BAND_LOW;
                    end else if (int'(sum) <= 4 * int'(high_thr)) begin
                        duty     = int'(DUTY_BASE) + (int'(sum) * 33) / 4096;
                        cmp      = PERIOD_W'(duty / 2);
                        tick     = '0;
                        running  = 1'b1;
                        res.band = BAND_MID;
                    end else begin
                        running  = 1'b0;
                        ind      = 1'b1;
                        res.band = BAND_HIGH;
                    end
                    band_hits[int'(res.band)]++;
                    count = '0;
                    sum   = '0;
                end else begin
                    count = count + 1'b1;
                end
            end
            res.pwm_out       = level;
            res.indicator_out = ind;
            res.pwm_active    = running;
            items++;
            expected_levels.push_back(res);
        endfunction

        function void check_levels(logic pwm, logic indic, logic active, logic bvalid,
                                   logic [1:0] band);
            t_result exp;
            if (expected_levels.size() == 0) begin
                $error("result transaction with no expectation waiting");
                errors++;
                return;
            end
            exp = expected_levels.pop_front();
            if (pwm !== exp.pwm_out) begin
                $error("pwm_out: expected %0b, got %0b", exp.pwm_out, pwm);
                errors++;
            end
            if (indic !== exp.indicator_out) begin
                $error("indicator_out: expected %0b, got %0b", exp.indicator_out, indic);
                errors++;
            end
            if (active !== exp.pwm_active) begin
                $error("pwm_active: expected %0b, got %0b", exp.pwm_active, active);
                errors++;
            end
            if (bvalid !== exp.band_valid) begin
                $error("band_valid: expected %0b, got %0b", exp.band_valid, bvalid);
                errors++;
            end
            if (band !== 2'(exp.band)) begin
                $error("band: expected %0d, got %0d", 2'(exp.band), band);
                errors++;
            end
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 i_op        = 1'b0;
    logic [SAMPLE_W-1:0]  i_sample    = '0;
    logic                 i_stall     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic                 o_pwm_out;
    logic                 o_indicator_out;
    logic                 o_pwm_active;
    logic                 o_band_valid;
    logic [1:0]           o_band;
    logic                 o_cfg_ready;

    band_pwm_scoreboard band_sb;
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int group_slot      = 0;
    int settings_seen   = 0;
    int quiet_cycles    = 0;

    adc_average_band_pwm u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pwm_out       (o_pwm_out),
        .o_indicator_out (o_indicator_out),
        .o_pwm_active    (o_pwm_active),
        .o_band_valid    (o_band_valid),
        .o_band          (o_band),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // all handshakes are sampled on their pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                band_sb.apply_register(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall)
                band_sb.note_item(i_op, i_sample);
            if (o_valid && !i_stall)
                band_sb.check_levels(o_pwm_out, o_indicator_out, o_pwm_active,
                                     o_band_valid, o_band);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (i_valid && !o_stall)
                || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transaction for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] sample);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_op     <= op;
        i_sample <= sample;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (op == OP_SAMPLE)
            group_slot = (group_slot + 1) % 4;
    endtask

    // drop valid and let every outstanding result drain
    task automatic wait_idle();
        i_valid <= 1'b0;
        // wait for the edge at which the last accepted transaction is noted
        @(posedge i_clk);
        while (band_sb.pending() > 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int low, input int high, input logic [PERIOD_W-1:0] per,
                             input int sender_pct, input int receiver_pct, input int count);
        logic [CFG_DAT_W-1:0] pdata;
        logic [SAMPLE_W-1:0]  sample;
        int                   base;
        base = low;
        wait_idle();
        write_register(CFG_LOW_THRESHOLD, CFG_DAT_W'(low));
        write_register(CFG_HIGH_THRESHOLD, CFG_DAT_W'(high));
        // junk in the unused upper bits of the period write
        pdata = CFG_DAT_W'($urandom_range(4095));
        pdata[PERIOD_W-1:0] = per;
        write_register(CFG_PWM_PERIOD, pdata);
        write_register(CFG_UNUSED, CFG_DAT_W'($urandom_range(4095)));
        settings_seen++;
        sender_idle_pct = sender_pct;
        stall_pct       = receiver_pct;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 30) begin
                // one level per group of four, so the sum usually lands on the chosen spot
                if (group_slot == 0) begin
                    case ($urandom_range(7))
                        0: base = low;
                        1: base = (low < 4095) ? low + 1 : low;
                        2: base = high;
                        3: base = (high < 4095) ? high + 1 : high;
                        7: base = $urandom_range(4095);
                        default: base = (high > low) ? $urandom_range(high, low)
                                                     : $urandom_range(4095);
                    endcase
                end
                sample = ($urandom_range(9) < 2) ? SAMPLE_W'($urandom_range(4095))
                                                 : SAMPLE_W'(base);
                send_item(OP_SAMPLE, sample);
            end else begin
                send_item(OP_TICK, SAMPLE_W'($urandom_range(4095)));
            end
        end
    endtask

    initial begin
        int lo;
        int hi;
        band_sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: tick while stopped, band extremes and both boundaries
        send_item(OP_TICK, 12'hfff);
        repeat (4) send_item(OP_SAMPLE, 12'h000);
        repeat (4) send_item(OP_SAMPLE, 12'hfff);
        repeat (4) send_item(OP_SAMPLE, LOW_THRESHOLD_RST);
        repeat (4) send_item(OP_SAMPLE, HIGH_THRESHOLD_RST);
        repeat (8) send_item(OP_TICK, SAMPLE_W'($urandom_range(4095)));

        run_phase(1241, 2482, 10'd8,    0,  0,  120);
        run_phase(0,    4095, 10'd1023, 84, 0,  110);
        // lowered period below a running counter, then everything in the low band
        run_phase(4095, 0,    10'd1,    0,  84, 60);
        run_phase(900,  3100, 10'd0,    15, 15, 120);
        // compare value beyond the period keeps the pin high
        run_phase(2000, 2100, 10'd3,    0,  0,  120);
        lo = $urandom_range(3000);
        hi = lo + $urandom_range(4095 - lo);
        run_phase(lo, hi, PERIOD_W'($urandom_range(40, 1)), 84, 0, 120);
        run_phase(600,  3500, 10'd20,   0,  84, 120);
        lo = $urandom_range(3000);
        hi = lo + $urandom_range(4095 - lo);
        run_phase(lo, hi, PERIOD_W'($urandom_range(60, 5)), 15, 15, 150);

        wait_idle();
        repeat (2 * LATENCY + 4) @(posedge i_clk);
        $display("covered %0d transactions, %0d averages (low %0d, mid %0d, high %0d)",
                 band_sb.items, band_sb.band_hits[0] + band_sb.band_hits[1]
                 + band_sb.band_hits[2], band_sb.band_hits[0], band_sb.band_hits[1],
                 band_sb.band_hits[2]);
        $display("across %0d register settings with sender gaps and receiver stalls",
                 settings_seen);
        if (band_sb.errors == 0 && band_sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
